### hdl/cpc_pkg.sv
package cpc_pkg;

   localparam int BodyCountDef = 256;
   localparam int MaxPointsDef = 4;

   localparam logic [23:0] SlopReset = 24'd66;
   localparam logic [15:0] GainReset = 16'd32768;

   // register indexes
   localparam logic [0:0] RegSlop = 1'b0;
   localparam logic [0:0] RegGain = 1'b1;

   // status codes
   localparam logic [1:0] StatIgnored = 2'd0;
   localparam logic [1:0] StatApplied = 2'd1;
   localparam logic [1:0] StatSkipped = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_DIFF,
      ST_DOT,
      ST_SCALE,
      ST_DIV,
      ST_MUL,
      ST_WRA,
      ST_RDB,
      ST_WRB,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic load;
      logic rd_a;
      logic diff;
      logic dot;
      logic scale;
      logic div_start;
      logic mul;
      logic wr_a;
      logic rd_b;
      logic wr_b;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic skip;
      logic apply;
      logic div_done;
   } stat_type;

endpackage

### hdl/cpc_div.sv
// Restoring divider, one quotient bit per cycle.
module cpc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [25:0] divisor,
   output logic [47:0] quotient,
   output logic        done
);
   logic [47:0] q_ff, q_in;
   logic [26:0] r_ff, r_in;
   logic [25:0] d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff;
   logic [26:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff[25:0], q_ff[47]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[26]) begin
            r_in = trial;
            q_in = {q_ff[46:0], 1'b1};
         end else begin
            r_in = {r_ff[25:0], q_ff[47]};
            q_in = {q_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) busy_in = 1'b0;
      end
   end

   // done rises in the same cycle as the last quotient bit lands in q_ff
   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= busy_ff && (cnt_ff == 6'd47) && !start;
      end
   end

   assign quotient = q_ff;
   assign done = done_ff;
endmodule

### hdl/cpc_ctrl.sv
// Sequencer: clear sweep after reset, then one item at a time.
module cpc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  cpc_pkg::stat_type   stat,
   output cpc_pkg::cmd_type    cmd
);
   import cpc_pkg::*;

   state_type state_ff, state_in;
   logic      ov_ff, ov_in;
   logic [1:0] div_pass_ff, div_pass_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ov_ff <= 1'b0;
         div_pass_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
         div_pass_ff <= div_pass_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      ov_in = ov_ff;
      div_pass_in = div_pass_ff;
      req_tready = 1'b0;
      if (rsp_tready) ov_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_a = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_DOT;
         end
         ST_DOT: begin
            cmd.dot = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (stat.skip) state_in = ST_RDB;
            else if (!stat.apply) state_in = ST_RDB;
            else begin
               cmd.scale = 1'b1;
               cmd.div_start = 1'b1;
               div_pass_in = 2'd0;
               state_in = ST_DIV;
            end
         end
         // three divider runs: ratio A, ratio B, gain over point count
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.mul = 1'b1;
               if (div_pass_ff != 2'd2) begin
                  cmd.div_start = 1'b1;
                  div_pass_in = div_pass_ff + 2'd1;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_WRA;
         end
         ST_WRA: begin
            cmd.wr_a = 1'b1;
            state_in = ST_RDB;
         end
         ST_RDB: begin
            cmd.rd_b = 1'b1;
            state_in = ST_WRB;
         end
         ST_WRB: begin
            cmd.wr_b = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!ov_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               ov_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = ov_ff;
endmodule

### hdl/cpc_dp.sv
// Datapath: correction store, dot product, divider, per-axis update.
module cpc_dp #(
   parameter int BODY_COUNT = cpc_pkg::BodyCountDef,
   parameter int MAX_POINTS = cpc_pkg::MaxPointsDef
) (
   input  logic                clock,
   input  logic                reset,
   input  cpc_pkg::cmd_type    cmd,
   output cpc_pkg::stat_type   stat,
   input  logic [23:0]         slop,
   input  logic [15:0]         gain,
   input  logic [191:0]        req_word,
   input  logic                req_last,
   output logic [151:0]        rsp_word,
   output logic                rsp_last
);
   import cpc_pkg::*;
   localparam int IW = (BODY_COUNT > 1) ? $clog2(BODY_COUNT) : 1;
   localparam int PW = $clog2(MAX_POINTS + 1);

   logic signed [23:0] mem_x [BODY_COUNT];
   logic signed [23:0] mem_y [BODY_COUNT];
   logic signed [23:0] mem_z [BODY_COUNT];

   logic [IW-1:0] clr_ff;
   logic [IW-1:0] ia_ff, ib_ff, waddr, raddr;
   logic signed [15:0] n_ff [3];
   logic signed [23:0] off_ff [3];
   logic [23:0] ma_ff, mb_ff;
   logic [PW-1:0] p_ff;
   logic last_ff;
   logic signed [23:0] rd_ff [3];
   logic signed [23:0] ca_ff [3];
   logic signed [25:0] d_ff [3];
   logic signed [41:0] prod_ff [3];
   logic signed [44:0] s_full;
   logic signed [30:0] s_cur;
   logic signed [30:0] s_ff;
   logic [47:0] c_num;
   logic [47:0] ra_ff, rb_ff;
   logic [47:0] c_ff;
   logic [15:0] nmag [3];
   logic [43:0] cm_ff [3];
   logic [1:0] status_ff;
   logic signed [23:0] wdata [3];
   logic we;
   logic div_start, div_done;
   logic [47:0] div_num, div_q;
   logic [25:0] div_den;
   logic [1:0] div_phase_ff;
   logic signed [23:0] fin_a [3];
   logic signed [23:0] wdata_b_ff [3];
   logic [2:0] p_raw;
   logic [PW-1:0] p_cl;

   // point count clamp
   always_comb begin
      p_raw = req_word[186:184];
      if (p_raw == 3'd0) p_cl = PW'(1);
      else if (32'(p_raw) > MAX_POINTS) p_cl = PW'(MAX_POINTS);
      else p_cl = PW'(p_raw);
   end

   // store port
   always_comb begin
      we = cmd.clear_wr | cmd.wr_a | cmd.wr_b;
      waddr = cmd.clear_wr ? clr_ff : (cmd.wr_a ? ia_ff : ib_ff);
      raddr = cmd.rd_b ? ib_ff : ia_ff;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_x[waddr] <= wdata[0];
         mem_y[waddr] <= wdata[1];
         mem_z[waddr] <= wdata[2];
      end
      rd_ff[0] <= mem_x[raddr];
      rd_ff[1] <= mem_y[raddr];
      rd_ff[2] <= mem_z[raddr];
   end

   // second read port: body B during the read stage
   logic signed [23:0] rb_x_ff [3];
   always_ff @(posedge clock) begin
      rb_x_ff[0] <= mem_x[ib_ff];
      rb_x_ff[1] <= mem_y[ib_ff];
      rb_x_ff[2] <= mem_z[ib_ff];
   end

   assign stat.clear_last = (32'(clr_ff) == BODY_COUNT - 1);

   // per-axis signed update with saturation; cm is |c * n|
   function automatic logic signed [23:0] upd(input logic signed [23:0] cur,
         input logic [43:0] cm, input logic neg, input logic [16:0] r,
         input logic sub);
      logic [60:0] full;
      logic signed [49:0] q;
      logic signed [49:0] res;
      full = 61'(cm) * 61'(r);
      q = 50'(full >> 30);
      if (neg) q = -q;
      res = sub ? 50'(cur) - q : 50'(cur) + q;
      if (res > 50'sd8388607) return 24'sh7FFFFF;
      if (res < -50'sd8388608) return -24'sh800000;
      return res[23:0];
   endfunction

   // |n| per axis
   always_comb begin
      for (int k = 0; k < 3; k++) nmag[k] = n_ff[k][15] ? 16'(-n_ff[k]) : n_ff[k];
   end

   // c times |n|, registered from c_ff
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) cm_ff[k] <= 44'(c_ff[28:0]) * 44'(nmag[k]);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (cmd.clear_wr) wdata[k] = '0;
         else if (status_ff == StatApplied)
            wdata[k] = upd(cmd.wr_a ? ca_ff[k] : rd_ff[k], cm_ff[k], n_ff[k][15],
                           cmd.wr_a ? ra_ff[16:0] : rb_ff[16:0], cmd.wr_a);
         else wdata[k] = cmd.wr_a ? ca_ff[k] : rd_ff[k];
      end
   end

   // dot product
   always_comb begin
      s_full = 45'(prod_ff[0]) + 45'(prod_ff[1]) + 45'(prod_ff[2]);
      s_cur = 31'(s_full >>> 14);
   end

   assign stat.skip = (ma_ff == '0) && (mb_ff == '0);
   assign stat.apply = (s_cur >= $signed({7'd0, slop}));
   assign stat.div_done = div_done;

   // c numerator: s * gain, s known >= 0 here
   assign c_num = 48'(s_ff[29:0]) * 48'(gain);

   always_comb begin
      if (cmd.scale) begin
         div_num = 48'({ma_ff, 16'd0});
         div_den = 26'(ma_ff) + 26'(mb_ff);
      end else if (div_phase_ff == 2'd0) begin
         div_num = 48'({mb_ff, 16'd0});
         div_den = 26'(ma_ff) + 26'(mb_ff);
      end else begin
         div_num = c_num;
         div_den = 26'(p_ff) << 15;
      end
   end
   assign div_start = cmd.div_start;

   cpc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .quotient(div_q), .done(div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_wr) clr_ff <= clr_ff + IW'(1);
      if (cmd.load) begin
         ia_ff <= IW'(req_word[7:0]);
         ib_ff <= IW'(req_word[15:8]);
         n_ff[0] <= req_word[31:16];
         n_ff[1] <= req_word[47:32];
         n_ff[2] <= req_word[63:48];
         off_ff[0] <= req_word[87:64];
         off_ff[1] <= req_word[111:88];
         off_ff[2] <= req_word[135:112];
         ma_ff <= req_word[159:136];
         mb_ff <= req_word[183:160];
         p_ff <= p_cl;
         last_ff <= req_last;
         status_ff <= StatIgnored;
      end
      if (cmd.diff) begin
         for (int k = 0; k < 3; k++) begin
            ca_ff[k] <= rd_ff[k];
            d_ff[k] <= 26'(off_ff[k]) + 26'(rd_ff[k]) - 26'(rb_x_ff[k]);
         end
      end
      if (cmd.dot) begin
         for (int k = 0; k < 3; k++) prod_ff[k] <= 42'(n_ff[k]) * 42'(d_ff[k]);
      end
      if (stat.skip && !cmd.load) status_ff <= StatSkipped;
      else if (cmd.scale) status_ff <= StatApplied;
      if (cmd.diff == 1'b0 && cmd.dot == 1'b0) s_ff <= s_cur;
      if (cmd.scale) div_phase_ff <= 2'd0;
      if (cmd.mul) begin
         if (div_phase_ff == 2'd0) ra_ff <= div_q;
         else if (div_phase_ff == 2'd1) rb_ff <= div_q;
         else c_ff <= div_q;
         div_phase_ff <= div_phase_ff + 2'd1;
      end
      if (cmd.wr_a) begin
         for (int k = 0; k < 3; k++) ca_ff[k] <= wdata[k];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_b) for (int k = 0; k < 3; k++) wdata_b_ff[k] <= wdata[k];
   end

   // same body on both sides: A shows the value after the B update
   always_comb begin
      for (int k = 0; k < 3; k++) fin_a[k] = (ia_ff == ib_ff) ? wdata_b_ff[k] : ca_ff[k];
   end

   assign rsp_word = {6'd0, status_ff, wdata_b_ff[2], wdata_b_ff[1], wdata_b_ff[0],
                      fin_a[2], fin_a[1], fin_a[0]};
   assign rsp_last = last_ff;
endmodule

### hdl/contact_position_correction_core.sv
// A corrected item takes three divider runs (mass ratio A, mass ratio B, gain over
// point count) between accept and rsp_tvalid; other items skip the divider.
// Flow: one item at a time; a result word
// still waiting at the output stalls the next one.
// Reset: synchronous, active high; control and config registers return to defaults,
// then a clearing pass zeroes all BODY_COUNT store entries before req_tready rises.
module contact_position_correction_core #(
   parameter int BODY_COUNT = cpc_pkg::BodyCountDef,
   parameter int MAX_POINTS = cpc_pkg::MaxPointsDef
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // body_a_index, body_b_index, normal_x/y/z, offset_x/y/z, inv_mass_a,
   // inv_mass_b, points_in_contact (zero fill)
   input  logic [191:0] req_tdata,
   input  logic         req_tlast,   // end_of_pass
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_offset_a_x/y/z, new_offset_b_x/y/z, status (zero fill)
   output logic [151:0] rsp_tdata,
   output logic         rsp_tlast,   // pass_done
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [23:0]  csr_data
);
   import cpc_pkg::*;

   logic [23:0] slop_ff;
   logic [15:0] gain_ff;
   cmd_type  cmd;
   stat_type stat;
   logic [151:0] word;
   logic last;

   assign csr_ready = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slop_ff <= SlopReset;
         gain_ff <= GainReset;
      end else if (csr_valid) begin
         if (csr_index == RegSlop) slop_ff <= csr_data;
         if (csr_index == RegGain) gain_ff <= csr_data[15:0];
      end
   end

   cpc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .stat(stat), .cmd(cmd)
   );

   cpc_dp #(.BODY_COUNT(BODY_COUNT), .MAX_POINTS(MAX_POINTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .slop(slop_ff),
      .gain(gain_ff), .req_word(req_tdata), .req_last(req_tlast), .rsp_word(word),
      .rsp_last(last)
   );

   // output held while waiting
   logic [151:0] rsp_ff;
   logic         rlast_ff;
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= word;
         rlast_ff <= last;
      end
   end
   assign rsp_tdata = rsp_ff;
   assign rsp_tlast = rlast_ff;

   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("rsp changed");
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.wr_a) else $error("write while idle");
endmodule

### tb/tb.sv
`timescale 1ns / 100ps

import cpc_pkg::*;

// one contact point as driven on the request stream
typedef struct {
   logic [7:0]  idx_a;
   logic [7:0]  idx_b;
   logic signed [15:0] nrm [3];
   logic signed [23:0] ofs [3];
   logic [23:0] mass_a;
   logic [23:0] mass_b;
   logic [2:0]  points;
   logic        last;
} contact_type;

// expected response word
typedef struct {
   logic [23:0] corr_a [3];
   logic [23:0] corr_b [3];
   logic [1:0]  status;
   logic        done;
} corr_result_type;

class correction_scoreboard;
   logic signed [23:0] store [3][256];
   logic [23:0] slop;
   logic [15:0] gain;
   corr_result_type pending [$];
   int mismatches;

   function new();
      mismatches = 0;
      slop = SlopReset;
      gain = GainReset;
      foreach (store[k, i]) store[k][i] = '0;
   endfunction

   static function longint floor_div_pow2(longint x, int sh);
      if (x >= 0) return x >>> sh;
      return -(((-x) - 1) >>> sh) - 1;
   endfunction

   static function longint sat24(longint x);
      if (x > 8388607) return 8388607;
      if (x < -8388608) return -8388608;
      return x;
   endfunction

   // signed share of the correction along one normal axis, toward zero
   static function longint axis_share(longint c, longint n, longint r);
      longint mag;
      longint q;
      logic [63:0] prod;
      mag = (n < 0) ? -n : n;
      prod = 64'(c * mag) * 64'(r);
      q = longint'(prod >> 30);
      return (n < 0) ? -q : q;
   endfunction

   // predict the response for one accepted contact and update the store
   function void note_contact(contact_type c);
      longint d [3];
      longint sep, ma, mb, sum, ra, rb, cor, pts;
      corr_result_type e;
      ma = c.mass_a;
      mb = c.mass_b;
      pts = c.points;
      if (pts < 1) pts = 1;
      if (pts > 4) pts = 4;
      for (int k = 0; k < 3; k++)
         d[k] = longint'(c.ofs[k]) + longint'(store[k][c.idx_a]) - longint'(store[k][c.idx_b]);
      e.status = StatIgnored;
      if (ma == 0 && mb == 0) begin
         e.status = StatSkipped;
      end else begin
         sep = floor_div_pow2(longint'(c.nrm[0]) * d[0] + longint'(c.nrm[1]) * d[1]
                              + longint'(c.nrm[2]) * d[2], 14);
         if (sep >= longint'(slop)) begin
            sum = ma + mb;
            ra = (ma << 16) / sum;
            rb = (mb << 16) / sum;
            cor = (sep * longint'(gain)) / (pts * 32768);
            e.status = StatApplied;
            for (int k = 0; k < 3; k++)
               store[k][c.idx_a] = 24'(sat24(longint'(store[k][c.idx_a])
                                   - axis_share(cor, c.nrm[k], ra)));
            for (int k = 0; k < 3; k++)
               store[k][c.idx_b] = 24'(sat24(longint'(store[k][c.idx_b])
                                   + axis_share(cor, c.nrm[k], rb)));
         end
      end
      for (int k = 0; k < 3; k++) begin
         e.corr_a[k] = store[k][c.idx_a];
         e.corr_b[k] = store[k][c.idx_b];
      end
      e.done = c.last;
      pending.push_back(e);
   endfunction

   // compare one accepted response word with the oldest expectation
   function void check_result(logic [151:0] data, logic last);
      corr_result_type e;
      logic [151:0] want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response word %h", data);
         return;
      end
      e = pending.pop_front();
      want = {6'b0, e.status, e.corr_b[2], e.corr_b[1], e.corr_b[0],
              e.corr_a[2], e.corr_a[1], e.corr_a[0]};
      if (data !== want || last !== e.done) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected %h last %b, got %h last %b", want, e.done, data, last);
      end
   endfunction
endclass

module tb;
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [151:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [0:0]   csr_index = '0;
   logic [23:0]  csr_data = '0;

   int send_idle_pct;
   int recv_idle_pct;
   correction_scoreboard board;

   contact_position_correction_core dut (.*);

   always #1 clock = ~clock;

   // response side: random stall, check on handshake
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tlast);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_reg(logic [0:0] idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == RegSlop) board.slop = val;
      else board.gain = val[15:0];
      @(posedge clock);
   endtask

   // valid stays up after the handshake; the next idle or drain drops it
   task automatic send_contact(contact_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {21'b0, c.points, c.mass_b, c.mass_a, c.ofs[2], c.ofs[1], c.ofs[0],
                    c.nrm[2], c.nrm[1], c.nrm[0], c.idx_b, c.idx_a};
      req_tlast <= c.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_contact(c);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // random contact; small index pool keeps bodies interacting
   function automatic contact_type random_contact();
      contact_type c;
      c.idx_a = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
      c.idx_b = ($urandom_range(7) == 0) ? c.idx_a : 8'($urandom_range(7));
      if ($urandom_range(15) == 0) c.idx_b = 8'($urandom);
      for (int k = 0; k < 3; k++) begin
         c.nrm[k] = ($urandom_range(9) == 0) ? 16'($urandom)
                    : 16'($signed($urandom_range(32768)) - 16384);
         case ($urandom_range(3))
            0: c.ofs[k] = 24'($urandom);
            1: c.ofs[k] = ($urandom_range(1)) ? 24'h7FFFFF : 24'h800000;
            default: c.ofs[k] = 24'($signed($urandom_range(262144)) - 131072);
         endcase
      end
      case ($urandom_range(7))
         0: begin c.mass_a = 0; c.mass_b = 0; end
         1: begin c.mass_a = 0; c.mass_b = 24'($urandom); end
         2: begin c.mass_a = 24'($urandom); c.mass_b = 0; end
         3: begin c.mass_a = 24'hFFFFFF; c.mass_b = 24'($urandom); end
         default: begin
            c.mass_a = 24'($urandom_range(131072));
            c.mass_b = 24'($urandom_range(131072));
         end
      endcase
      c.points = 3'($urandom);
      c.last = ($urandom_range(7) == 0);
      return c;
   endfunction

   function automatic contact_type plain_contact(logic [7:0] a, logic [7:0] b);
      contact_type c;
      c.idx_a = a;
      c.idx_b = b;
      c.nrm[0] = 16'sd16384; c.nrm[1] = 0; c.nrm[2] = 0;
      c.ofs[0] = 24'sd65536; c.ofs[1] = 0; c.ofs[2] = 0;
      c.mass_a = 24'd65536; c.mass_b = 24'd65536;
      c.points = 3'd1;
      c.last = 1'b0;
      return c;
   endfunction

   initial begin
      contact_type c;
      board = new();
      send_idle_pct = 7;
      recv_idle_pct = 63;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: basic applied case, shared index, masses, extremes
      send_contact(plain_contact(0, 1));
      send_contact(plain_contact(2, 2));
      c = plain_contact(3, 4); c.mass_a = 0; c.mass_b = 0; send_contact(c);
      c = plain_contact(3, 4); c.mass_a = 0; send_contact(c);
      c = plain_contact(3, 4); c.mass_b = 0; c.last = 1; send_contact(c);
      c = plain_contact(5, 6); c.ofs[0] = 24'sd10; send_contact(c);
      for (int p = 0; p < 8; p++) begin
         c = plain_contact(7, 8); c.points = 3'(p); send_contact(c);
      end
      c = plain_contact(255, 0);
      c.nrm[0] = 16'h7FFF; c.nrm[1] = 16'h8000; c.nrm[2] = 16'hC000;
      c.ofs[0] = 24'h7FFFFF; c.ofs[1] = 24'h800000; c.ofs[2] = 24'h800000;
      c.mass_a = 24'hFFFFFF; c.mass_b = 24'hFFFFFF; c.points = 3'd7; c.last = 1;
      repeat (4) send_contact(c);
      c = plain_contact(254, 253); c.nrm[0] = -16'sd16384; c.ofs[0] = -24'sd65536;
      send_contact(c);
      drain();

      // extreme register settings
      write_reg(RegSlop, 24'd0);
      write_reg(RegGain, 24'hFFFF);
      for (int i = 0; i < 8; i++) send_contact(random_contact());
      drain();
      write_reg(RegSlop, 24'hFFFFFF);
      write_reg(RegGain, 24'd0);
      for (int i = 0; i < 8; i++) send_contact(random_contact());
      drain();

      // random phases with changing settings and idling
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin send_idle_pct = 63; recv_idle_pct = 7; end
         if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
         for (int sub = 0; sub < 4; sub++) begin
            write_reg(RegSlop, ($urandom_range(2) == 0) ? 24'($urandom) : 24'($urandom_range(200)));
            write_reg(RegGain, 24'($urandom_range(65535)));
            for (int i = 0; i < 100; i++) send_contact(random_contact());
            drain();
         end
      end

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("contact_position_correction_core test passed");
      end else begin
         $display("contact_position_correction_core test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("contact_position_correction_core test failed");
      $finish;
   end
endmodule

### sim.f
hdl/cpc_pkg.sv
hdl/cpc_div.sv
hdl/cpc_ctrl.sv
hdl/cpc_dp.sv
hdl/contact_position_correction_core.sv
tb/tb.sv
